@@ rtl/jjss_pkg.sv @@
package jjss_pkg;

   localparam int JOINT_COUNT = 6;
   localparam int AXIS_COUNT  = 4;
   localparam int AXIS_W      = 10;
   localparam int ANGLE_W     = 8;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_REST = 8'd90;

   // register reset values
   localparam logic [9:0] CENTER_RESET = 10'd511;
   localparam logic [8:0] DEAD_RESET   = 9'd70;
   localparam logic [8:0] FAST_RESET   = 9'd350;
   localparam logic [7:0] STEP_RESET   = 8'd3;

   // register indexes
   localparam logic [1:0] REG_STICK_CENTER = 2'd0;
   localparam logic [1:0] REG_DEAD_BAND    = 2'd1;
   localparam logic [1:0] REG_FAST_OFFSET  = 2'd2;
   localparam logic [1:0] REG_SLEW_STEP    = 2'd3;

   typedef logic signed [2:0] jog_type;

   localparam jog_type JOG_NEG2 = -3'sd2;
   localparam jog_type JOG_NEG1 = -3'sd1;
   localparam jog_type JOG_ZERO = 3'sd0;
   localparam jog_type JOG_POS1 = 3'sd1;
   localparam jog_type JOG_POS2 = 3'sd2;

   typedef struct packed {
      logic [9:0] center;
      logic [8:0] dead;
      logic [8:0] fast;
   } thresh_type;

endpackage

@@ rtl/joystick_jog_servo_slew.sv @@
// channel   | direction | tdata fields (lsb up)                         | tuser
// ----------+-----------+-----------------------------------------------+------------
// req_      | in        | axis_y1, axis_x1, axis_y2, axis_x2 (10b each) | pair_select
// rsp_      | out       | joint1_angle .. joint6_angle (8b each)        | -
// csr_      | in        | write only: csr_index selects, csr_wdata data | -
//
// one tick transaction per cycle while req_tready is high; its result is in the
// output register in the cycle after acceptance. jog classification, goal clamp
// and slew all settle in the accept cycle across four axis lanes and six joint lanes.
// reset (synchronous) restores registers to 511/70/350/3 and all angles to 90.
// req_tready drops only while a result waits and rsp_tready is low.
module joystick_jog_servo_slew import jjss_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [AXIS_COUNT*AXIS_W-1:0]  req_tdata,  // axis_y1, axis_x1, axis_y2, axis_x2
   input  logic                          req_tuser,  // pair_select
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [JOINT_COUNT*ANGLE_W-1:0] rsp_tdata, // joint1_angle .. joint6_angle
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [9:0]                    csr_wdata
);

   // configuration registers
   logic [9:0] center_ff;
   logic [8:0] dead_ff;
   logic [8:0] fast_ff;
   logic [7:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         dead_ff   <= DEAD_RESET;
         fast_ff   <= FAST_RESET;
         step_ff   <= STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_STICK_CENTER: center_ff <= csr_wdata;
            REG_DEAD_BAND:    dead_ff   <= csr_wdata[8:0];
            REG_FAST_OFFSET:  fast_ff   <= csr_wdata[8:0];
            REG_SLEW_STEP:    step_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   thresh_type thresh;
   assign thresh = '{center: center_ff, dead: dead_ff, fast: fast_ff};

   // handshake: output register parts the two sides
   logic accept;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // axis lanes
   jog_type axis_jog [AXIS_COUNT];

   for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_axis
      jjss_jog_lane u_jog (
         .axis   (req_tdata[a*AXIS_W +: AXIS_W]),
         .thresh (thresh),
         .jog    (axis_jog[a])
      );
   end

   // route the second stick to joints 3-4 or 5-6
   jog_type joint_jog [JOINT_COUNT];

   always_comb begin
      joint_jog[0] = axis_jog[0];
      joint_jog[1] = axis_jog[1];
      joint_jog[2] = req_tuser ? JOG_ZERO : axis_jog[2];
      joint_jog[3] = req_tuser ? JOG_ZERO : axis_jog[3];
      joint_jog[4] = req_tuser ? axis_jog[2] : JOG_ZERO;
      joint_jog[5] = req_tuser ? axis_jog[3] : JOG_ZERO;
   end

   // joint lanes and angle state
   logic [ANGLE_W-1:0] goal_ff    [JOINT_COUNT];
   logic [ANGLE_W-1:0] present_ff [JOINT_COUNT];
   logic [ANGLE_W-1:0] goal_in    [JOINT_COUNT];
   logic [ANGLE_W-1:0] present_in [JOINT_COUNT];

   for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_joint
      jjss_joint_lane u_joint (
         .goal         (goal_ff[j]),
         .present      (present_ff[j]),
         .jog          (joint_jog[j]),
         .step         (step_ff),
         .goal_next    (goal_in[j]),
         .present_next (present_in[j])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            goal_ff[j]    <= ANGLE_REST;
            present_ff[j] <= ANGLE_REST;
         end else if (accept) begin
            goal_ff[j]    <= goal_in[j];
            present_ff[j] <= present_in[j];
         end
      end
   end

   // merge the lanes into one result word
   logic [JOINT_COUNT*ANGLE_W-1:0] rsp_data_in;
   logic [JOINT_COUNT*ANGLE_W-1:0] rsp_data_ff;

   always_comb begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
         rsp_data_in[j*ANGLE_W +: ANGLE_W] = present_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/jjss_jog_lane.sv @@
module jjss_jog_lane import jjss_pkg::*; (
   input  logic [AXIS_W-1:0] axis,
   input  thresh_type        thresh,
   output jog_type           jog
);

   logic [AXIS_W:0] axis_ext;
   logic [AXIS_W:0] center_ext;
   logic [AXIS_W:0] up_dead;
   logic [AXIS_W:0] up_fast;
   logic [AXIS_W:0] dn_dead;
   logic [AXIS_W:0] dn_fast;

   // lower tests written as axis + offset < center to stay unsigned
   assign axis_ext   = {1'b0, axis};
   assign center_ext = {1'b0, thresh.center};
   assign up_dead    = center_ext + {2'b00, thresh.dead};
   assign up_fast    = center_ext + {2'b00, thresh.fast};
   assign dn_dead    = axis_ext + {2'b00, thresh.dead};
   assign dn_fast    = axis_ext + {2'b00, thresh.fast};

   always_comb begin
      if (axis_ext > up_dead) begin
         jog = (axis_ext > up_fast) ? JOG_POS2 : JOG_POS1;
      end else if (dn_dead < center_ext) begin
         jog = (dn_fast < center_ext) ? JOG_NEG2 : JOG_NEG1;
      end else begin
         jog = JOG_ZERO;
      end
   end

endmodule

@@ rtl/jjss_joint_lane.sv @@
module jjss_joint_lane import jjss_pkg::*; (
   input  logic [ANGLE_W-1:0] goal,
   input  logic [ANGLE_W-1:0] present,
   input  jog_type            jog,
   input  logic [7:0]         step,
   output logic [ANGLE_W-1:0] goal_next,
   output logic [ANGLE_W-1:0] present_next
);

   logic signed [ANGLE_W+1:0] goal_sum;
   logic [ANGLE_W-1:0]        delta;
   logic [ANGLE_W-1:0]        move;

   assign goal_sum = $signed({2'b00, goal}) + (ANGLE_W+2)'(jog);

   always_comb begin
      if (goal_sum < 0) begin
         goal_next = '0;
      end else if (goal_sum > $signed({2'b00, ANGLE_MAX})) begin
         goal_next = ANGLE_MAX;
      end else begin
         goal_next = goal_sum[ANGLE_W-1:0];
      end
   end

   // step limited to the remaining distance, no overshoot
   always_comb begin
      delta = (goal_next > present) ? (goal_next - present) : (present - goal_next);
      move  = (delta < step) ? delta : step;
      if (goal_next > present) begin
         present_next = present + move;
      end else begin
         present_next = present - move;
      end
   end

endmodule

@@ rtl/jjss_checker.sv @@
module jjss_checker import jjss_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [JOINT_COUNT*ANGLE_W-1:0] rsp_tdata
);

   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every accepted tick yields a result next cycle
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick gave no result");

   // input side only blocks behind a stalled result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // angles stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] <= ANGLE_MAX && rsp_tdata[15:8] <= ANGLE_MAX &&
                     rsp_tdata[23:16] <= ANGLE_MAX && rsp_tdata[31:24] <= ANGLE_MAX &&
                     rsp_tdata[39:32] <= ANGLE_MAX && rsp_tdata[47:40] <= ANGLE_MAX)
      else $error("angle out of range");

   // nothing pending after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind joystick_jog_servo_slew jjss_checker u_jjss_checker (.*);
